// ===== rtl/core/atrc_pkg.sv =====
// Shared constants, types and match-text functions for the AT response line classifier.
`timescale 1ns / 1ps

package atrc_pkg;

  localparam int LINE_CAP   = 64;
  localparam int CNT_W      = $clog2(LINE_CAP + 1);
  localparam int POS_W      = $clog2(LINE_CAP);
  localparam int PROMPT_LEN = 4;
  localparam int ECHO_LEN   = 7;
  localparam int TAG_LEN    = 9;
  localparam int TAG_W      = 4;
  localparam int MIN_HELD   = 3;

  localparam logic [7:0] LF_BYTE  = 8'h0A;
  localparam logic [7:0] TAG_HEAD = 8'h2B;  // '+'

  typedef struct packed {
    logic             store;
    logic             shift;
    logic [POS_W-1:0] wr_pos;
  } atrc_chain_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } atrc_state_t;

  // CR LF '>' ' '
  function automatic logic [7:0] prompt_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      POS_W'(0): c = 8'h0D;
      POS_W'(1): c = 8'h0A;
      POS_W'(2): c = 8'h3E;
      POS_W'(3): c = 8'h20;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  // "ATE0" CR CR LF
  function automatic logic [7:0] echo_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    case (pos)
      POS_W'(0): c = 8'h41;
      POS_W'(1): c = 8'h54;
      POS_W'(2): c = 8'h45;
      POS_W'(3): c = 8'h30;
      POS_W'(4): c = 8'h0D;
      POS_W'(5): c = 8'h0D;
      POS_W'(6): c = 8'h0A;
      default:   c = 8'h00;
    endcase
    return c;
  endfunction

  // "+QMTRECV:"
  function automatic logic [7:0] tag_char(input logic [TAG_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h2B;
      4'd1:    c = 8'h51;
      4'd2:    c = 8'h4D;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h52;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h43;
      4'd7:    c = 8'h56;
      4'd8:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/at_response_line_classifier.sv =====
// Top level: line gathering, prompt/echo/tag matching and line readout control.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid, in_stall, in_rx_byte): one modem byte per transfer.
//   Output channel (out_valid, out_stall, out_*): one line byte per transfer,
//   with the server-data tag, a last-byte mark and an overflow mark.
//   A byte is taken whenever the block is gathering. When it ends a
//   line that is not the echo, the block raises in_stall and reads the line out
//   of the cell chain head, one byte per cycle while the receiver takes them;
//   the ending transfer sets the state register to readout, and the first line
//   byte is then loaded into the output register. The readout rate is set by
//   the single shift of the chain per cycle.
//   A stalled result holds in the output register and the chain waits; the
//   last byte may still be waiting while the next input transfer is taken.
//   Reset (synchronous, rst_n low) empties the line and clears both channels'
//   control state; the chain contents need no reset, since only written cells
//   are ever read.
module at_response_line_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_line_byte,
  output logic       out_from_server,
  output logic       out_last_byte,
  output logic       out_overflowed
);
  import atrc_pkg::*;

  atrc_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TAG_W-1:0] tag_prog_r, tag_prog_nxt;
  logic             tag_seen_r, tag_seen_nxt;
  logic             prompt_r, prompt_nxt;
  logic             echo_r, echo_nxt;
  logic             drop_r, drop_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             emit_srv_r, emit_srv_nxt;
  logic             emit_ovf_r, emit_ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_srv_r, out_last_r, out_ovf_r;

  atrc_chain_ctl_t  ctl;
  logic [7:0]       head_byte;
  logic             acc, store_ok, ends, out_load, emit;

  atrc_line_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .wr_byte   (in_rx_byte),
    .head_byte (head_byte)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign store_ok = count_r < CNT_W'(LINE_CAP);
  assign out_load = !out_valid_r || !out_stall;
  assign emit     = (state_r == ST_EMIT) && out_load;

  assign ctl.store  = acc && store_ok;
  assign ctl.shift  = emit;
  assign ctl.wr_pos = count_r[POS_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    tag_prog_nxt = tag_prog_r;
    tag_seen_nxt = tag_seen_r;
    prompt_nxt   = prompt_r;
    echo_nxt     = echo_r;
    drop_nxt     = drop_r;
    remain_nxt   = remain_r;
    emit_srv_nxt = emit_srv_r;
    emit_ovf_nxt = emit_ovf_r;
    ends         = 1'b0;

    if (acc) begin
      if (store_ok) begin
        prompt_nxt = prompt_r && (count_r < CNT_W'(PROMPT_LEN)) &&
                     (in_rx_byte == prompt_char(count_r[POS_W-1:0]));
        echo_nxt   = echo_r && (count_r < CNT_W'(ECHO_LEN)) &&
                     (in_rx_byte == echo_char(count_r[POS_W-1:0]));
        if (!tag_seen_r) begin
          if (tag_prog_r < TAG_W'(TAG_LEN) && in_rx_byte == tag_char(tag_prog_r)) begin
            tag_prog_nxt = tag_prog_r + TAG_W'(1);
            if (tag_prog_r == TAG_W'(TAG_LEN - 1)) begin
              tag_seen_nxt = 1'b1;
            end
          end else begin
            tag_prog_nxt = (in_rx_byte == TAG_HEAD) ? TAG_W'(1) : TAG_W'(0);
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end

      ends = (count_nxt > CNT_W'(MIN_HELD)) &&
             ((in_rx_byte == LF_BYTE) || (prompt_nxt && count_nxt == CNT_W'(PROMPT_LEN)));

      if (ends) begin
        // echo lines vanish; everything else goes to readout
        if (!(echo_nxt && count_nxt == CNT_W'(ECHO_LEN) && !drop_nxt)) begin
          state_nxt    = ST_EMIT;
          remain_nxt   = count_nxt;
          emit_srv_nxt = tag_seen_nxt;
          emit_ovf_nxt = drop_nxt;
        end
        count_nxt    = '0;
        tag_prog_nxt = '0;
        tag_seen_nxt = 1'b0;
        prompt_nxt   = 1'b1;
        echo_nxt     = 1'b1;
        drop_nxt     = 1'b0;
      end
    end

    if (emit) begin
      remain_nxt = remain_r - CNT_W'(1);
      if (remain_r == CNT_W'(1)) begin
        state_nxt = ST_IDLE;
      end
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      tag_prog_r  <= '0;
      tag_seen_r  <= 1'b0;
      prompt_r    <= 1'b1;
      echo_r      <= 1'b1;
      drop_r      <= 1'b0;
      remain_r    <= '0;
      emit_srv_r  <= 1'b0;
      emit_ovf_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tag_prog_r  <= tag_prog_nxt;
      tag_seen_r  <= tag_seen_nxt;
      prompt_r    <= prompt_nxt;
      echo_r      <= echo_nxt;
      drop_r      <= drop_nxt;
      remain_r    <= remain_nxt;
      emit_srv_r  <= emit_srv_nxt;
      emit_ovf_r  <= emit_ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= head_byte;
      out_srv_r  <= emit_srv_r;
      out_last_r <= (remain_r == CNT_W'(1));
      out_ovf_r  <= emit_ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_byte   = out_byte_r;
  assign out_from_server = out_srv_r;
  assign out_last_byte   = out_last_r;
  assign out_overflowed  = out_ovf_r;

endmodule

// ===== rtl/core/atrc_cell.sv =====
// One byte cell of the line chain: loads a received byte or takes its neighbor's byte.
`timescale 1ns / 1ps

module atrc_cell (
  input  logic       clk,
  input  logic       load_en,
  input  logic       shift_en,
  input  logic [7:0] load_byte,
  input  logic [7:0] nb_byte,
  output logic [7:0] q_byte
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      byte_r <= load_byte;
    end else if (shift_en) begin
      byte_r <= nb_byte;
    end
  end

  assign q_byte = byte_r;

endmodule

// ===== rtl/core/atrc_line_chain.sv =====
// Row of byte cells holding the current line; oldest byte sits at the head (cell 0).
`timescale 1ns / 1ps

module atrc_line_chain (
  input  logic                      clk,
  input  atrc_pkg::atrc_chain_ctl_t ctl,
  input  logic [7:0]                wr_byte,
  output logic [7:0]                head_byte
);
  import atrc_pkg::*;

  logic [7:0] q [LINE_CAP];

  genvar i;
  generate
    for (i = 0; i < LINE_CAP; i++) begin : g_cell
      logic       ld;
      logic [7:0] nb;
      assign ld = ctl.store && (ctl.wr_pos == POS_W'(i));
      if (i == LINE_CAP - 1) begin : g_tail
        assign nb = 8'h00;
      end else begin : g_mid
        assign nb = q[i+1];
      end
      atrc_cell u_cell (
        .clk       (clk),
        .load_en   (ld),
        .shift_en  (ctl.shift),
        .load_byte (wr_byte),
        .nb_byte   (nb),
        .q_byte    (q[i])
      );
    end
  endgenerate

  assign head_byte = q[0];

endmodule
